FILE: rtl/core/stli_pkg.sv
package stli_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int YEAR_W  = 16;
    localparam int VAL_W   = 31;
    localparam int RAW_W   = 32;
    localparam int PROD_W  = 48;
    localparam int DCNT_W  = $clog2(PROD_W);

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_YEAR0    = 2'd1,
        ST_FULL     = 2'd2,
        ST_CLAMPED  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        RES_ZERO,
        RES_REJECT,
        RES_FULL,
        RES_STORE,
        RES_CUR,
        RES_PREV,
        RES_INTERP
    } t_res_sel;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DINIT,
        S_DIV,
        S_FIN,
        S_OUT
    } t_state;

    typedef struct packed {
        logic     load;
        logic     scan;
        logic     commit_ins;
        logic     commit_ovr;
        logic     mul;
        logic     div_init;
        logic     div_step;
        logic     res_load;
        t_res_sel res_sel;
        logic     res_hit;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        logic is_lookup;
        logic year_zero;
        logic empty;
        logic full;
        logic scan_done;
        logic slot_hit;
        logic slot_end;
        logic slot_first;
        logic div_last;
    } t_sts;

endpackage

FILE: rtl/core/stli_ctrl.sv
module stli_ctrl
    import stli_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_cmd.res_sel = RES_ZERO;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                if (!i_sts.is_lookup && i_sts.year_zero) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_sel  = RES_REJECT;
                    n_state        = S_OUT;
                end else if (!i_sts.scan_done) begin
                    o_cmd.scan = 1'b1;
                end else if (!i_sts.is_lookup) begin
                    o_cmd.res_load = 1'b1;
                    n_state        = S_OUT;
                    if (i_sts.slot_hit) begin
                        o_cmd.commit_ovr = 1'b1;
                        o_cmd.res_sel    = RES_STORE;
                        o_cmd.res_hit    = 1'b1;
                    end else if (i_sts.full) begin
                        o_cmd.res_sel = RES_FULL;
                    end else begin
                        o_cmd.commit_ins = 1'b1;
                        o_cmd.res_sel    = RES_STORE;
                    end
                end else begin
                    priority if (i_sts.empty) begin
                        o_cmd.res_load = 1'b1;
                        o_cmd.res_sel  = RES_ZERO;
                        n_state        = S_OUT;
                    end else if (i_sts.slot_hit) begin
                        o_cmd.res_load = 1'b1;
                        o_cmd.res_sel  = RES_CUR;
                        o_cmd.res_hit  = 1'b1;
                        n_state        = S_OUT;
                    end else if (i_sts.slot_end) begin
                        o_cmd.res_load = 1'b1;
                        o_cmd.res_sel  = RES_PREV;
                        n_state        = S_OUT;
                    end else if (i_sts.slot_first) begin
                        o_cmd.res_load = 1'b1;
                        o_cmd.res_sel  = RES_CUR;
                        n_state        = S_OUT;
                    end else begin
                        o_cmd.mul = 1'b1;
                        n_state   = S_DINIT;
                    end
                end
            end
            S_DINIT: begin
                o_cmd.div_init = 1'b1;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.res_load = 1'b1;
                o_cmd.res_sel  = RES_INTERP;
                n_state        = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

FILE: rtl/core/stli_dp.sv
module stli_dp
    import stli_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_op,
    input  logic [YEAR_W-1:0]        i_year,
    input  logic signed [RAW_W-1:0]  i_value,
    input  t_cmd                     i_cmd,
    output t_sts                     o_sts,
    output logic [VAL_W-1:0]         o_res_value,
    output logic                     o_res_hit,
    output logic [YEAR_W-1:0]        o_min_year,
    output logic [YEAR_W-1:0]        o_max_year,
    output t_status                  o_status
);

    logic [YEAR_W-1:0] r_years [TABLE_DEPTH];
    logic [VAL_W-1:0]  r_vals  [TABLE_DEPTH];
    logic [CNT_W-1:0]  r_count;
    logic [YEAR_W-1:0] r_min, r_max;

    logic              r_op;
    logic [YEAR_W-1:0] r_year;
    logic [VAL_W-1:0]  r_store;
    t_status           r_st;
    logic [CNT_W-1:0]  r_idx;
    logic [YEAR_W-1:0] r_prev_year;
    logic [VAL_W-1:0]  r_prev_val;

    logic signed [PROD_W:0] r_prod;
    logic [YEAR_W-1:0]      r_div;
    logic                   r_neg;
    logic [PROD_W-1:0]      r_quo;
    logic [YEAR_W:0]        r_rem;
    logic [DCNT_W-1:0]      r_dcnt;

    logic [VAL_W-1:0]  r_res_val;
    logic              r_res_hit;
    t_status           r_res_st;

    logic [VAL_W-1:0]  r_o_val;
    logic              r_o_hit;
    logic [YEAR_W-1:0] r_o_min, r_o_max;
    t_status           r_o_st;

    logic [YEAR_W-1:0] cur_year;
    logic [VAL_W-1:0]  cur_val;
    logic              at_end;
    logic [YEAR_W:0]   trial;
    logic              fits;
    logic [PROD_W-1:0] q_signed;
    logic [VAL_W-1:0]  interp;
    logic signed [RAW_W:0] dy;

    assign cur_year = r_years[r_idx[IDX_W-1:0]];
    assign cur_val  = r_vals[r_idx[IDX_W-1:0]];
    assign at_end   = (r_idx == r_count);

    assign o_sts.is_lookup  = r_op;
    assign o_sts.year_zero  = (r_year == '0);
    assign o_sts.empty      = (r_count == '0);
    assign o_sts.full       = (r_count == CNT_W'(TABLE_DEPTH));
    assign o_sts.scan_done  = at_end || (cur_year >= r_year);
    assign o_sts.slot_hit   = !at_end && (cur_year == r_year);
    assign o_sts.slot_end   = at_end;
    assign o_sts.slot_first = (r_idx == '0);
    assign o_sts.div_last   = (r_dcnt == DCNT_W'(PROD_W - 1));

    assign dy = $signed({2'b00, cur_val}) - $signed({2'b00, r_prev_val});

    assign trial = {r_rem[YEAR_W-1:0], r_quo[PROD_W-1]};
    assign fits  = (trial >= {1'b0, r_div});

    assign q_signed = r_neg ? (~r_quo + PROD_W'(1)) : r_quo;
    assign interp   = r_prev_val + q_signed[VAL_W-1:0];

    // table and bounds
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_min   <= '0;
            r_max   <= '0;
        end else if (i_cmd.commit_ins) begin
            r_count <= r_count + CNT_W'(1);
            if (r_count == '0) begin
                r_min <= r_year;
                r_max <= r_year;
            end else begin
                if (r_idx == '0) r_min <= r_year;
                if (at_end)      r_max <= r_year;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            if (i_cmd.commit_ins) begin
                if (IDX_W'(k) == r_idx[IDX_W-1:0]) begin
                    r_years[k] <= r_year;
                    r_vals[k]  <= r_store;
                end else if (k > 0 && CNT_W'(k) > r_idx) begin
                    r_years[k] <= r_years[(k > 0) ? k - 1 : 0];
                    r_vals[k]  <= r_vals[(k > 0) ? k - 1 : 0];
                end
            end else if (i_cmd.commit_ovr && IDX_W'(k) == r_idx[IDX_W-1:0]) begin
                r_vals[k] <= r_store;
            end
        end
    end

    // item capture and scan
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_op;
            r_year  <= i_year;
            r_idx   <= '0;
            r_store <= i_value[RAW_W-1] ? '0 : i_value[VAL_W-1:0];
            r_st    <= i_value[RAW_W-1] ? ST_CLAMPED : ST_OK;
        end else if (i_cmd.scan) begin
            r_idx       <= r_idx + CNT_W'(1);
            r_prev_year <= cur_year;
            r_prev_val  <= cur_val;
        end
    end

    // multiply, then bit-serial restoring divide
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod <= $signed({1'b0, r_year - r_prev_year}) * dy;
            r_div  <= cur_year - r_prev_year;
        end
        if (i_cmd.div_init) begin
            r_neg  <= r_prod[PROD_W];
            r_quo  <= r_prod[PROD_W] ? PROD_W'(-r_prod) : r_prod[PROD_W-1:0];
            r_rem  <= '0;
            r_dcnt <= '0;
        end else if (i_cmd.div_step) begin
            r_rem  <= fits ? (trial - {1'b0, r_div}) : trial;
            r_quo  <= {r_quo[PROD_W-2:0], fits};
            r_dcnt <= r_dcnt + DCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_res_hit <= i_cmd.res_hit;
            unique case (i_cmd.res_sel)
                RES_ZERO:   begin r_res_val <= '0;         r_res_st <= ST_OK;    end
                RES_REJECT: begin r_res_val <= '0;         r_res_st <= ST_YEAR0; end
                RES_FULL:   begin r_res_val <= '0;         r_res_st <= ST_FULL;  end
                RES_STORE:  begin r_res_val <= r_store;    r_res_st <= r_st;     end
                RES_CUR:    begin r_res_val <= cur_val;    r_res_st <= ST_OK;    end
                RES_PREV:   begin r_res_val <= r_prev_val; r_res_st <= ST_OK;    end
                RES_INTERP: begin r_res_val <= interp;     r_res_st <= ST_OK;    end
                default:    begin r_res_val <= '0;         r_res_st <= ST_OK;    end
            endcase
        end
        if (i_cmd.out_load) begin
            r_o_val <= r_res_val;
            r_o_hit <= r_res_hit;
            r_o_st  <= r_res_st;
            r_o_min <= r_min;
            r_o_max <= r_max;
        end
    end

    assign o_res_value = r_o_val;
    assign o_res_hit   = r_o_hit;
    assign o_min_year  = r_o_min;
    assign o_max_year  = r_o_max;
    assign o_status    = r_o_st;

endmodule

FILE: rtl/core/sorted_table_linear_interpolator_unit.sv
// Channel  | Dir | Port group       | Item contents (low bit first)
// slave    | in  | i_s_* / o_s_*    | tuser: operation; tdata: year, point_value
// master   | out | o_m_* / i_m_*    | tdata: result_value, exact_hit, min_year,
//          |     |                  |        max_year, status
//
// One item at a time. Insert: load, then a scan over k = entries before the slot
// (at most 16). Lookup: same, plus, when it interpolates, a divider load,
// 48 restoring divide steps and a final add; the 17x33 multiply runs in the last scan cycle.
// Synchronous active-low reset empties the table; table contents are not cleared.
// A result waits in the output register; input is taken again once it is loaded.
module sorted_table_linear_interpolator_unit
    import stli_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic        i_s_tuser,   // [0] operation
    input  logic [47:0] i_s_tdata,   // [15:0] year, [47:16] point_value
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [71:0] o_m_tdata    // [30:0] result_value, [31] exact_hit,
                                     // [47:32] min_year, [63:48] max_year,
                                     // [65:64] status, rest zero
);

    t_cmd              cmd;
    t_sts              sts;
    logic [VAL_W-1:0]  res_value;
    logic              res_hit;
    logic [YEAR_W-1:0] min_year, max_year;
    t_status           status;

    stli_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_tvalid),
        .o_in_ready  (o_s_tready),
        .o_out_valid (o_m_tvalid),
        .i_out_ready (i_m_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    stli_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (i_s_tuser),
        .i_year      (i_s_tdata[15:0]),
        .i_value     (i_s_tdata[47:16]),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_res_value (res_value),
        .o_res_hit   (res_hit),
        .o_min_year  (min_year),
        .o_max_year  (max_year),
        .o_status    (status)
    );

    assign o_m_tdata = {6'd0, status, max_year, min_year, res_hit, res_value};

    // one item in flight: no accept right after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("input accepted while an item is in progress");

    // a full-table result never reports an overwrite
    a_full_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[65:64] == ST_FULL |-> !o_m_tdata[31] &&
        o_m_tdata[30:0] == '0)
        else $error("table-full result carries data");

    // stored bounds stay ordered
    a_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[47:32] <= o_m_tdata[63:48])
        else $error("min year above max year");

endmodule
